// File: design/rc4_pkg.sv
`timescale 1ns / 1ps

package rc4_pkg;

   localparam int KEY_WORDS    = 4;
   localparam int KEY_WORD_W   = 64;
   localparam int KEY_BITS     = KEY_WORDS * KEY_WORD_W;
   localparam int KEY_LENGTH_W = 6;
   localparam int CSR_INDEX_W  = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_0 = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_1 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_2 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_WORD_3 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LENGTH = 3'd4;

   localparam logic [KEY_LENGTH_W-1:0] KEY_LENGTH_RESET = 6'd16;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] keystream_byte;
   } rsp_type;

endpackage

// File: design/rc4_perm_ram.sv
`timescale 1ns / 1ps

// 256 x 8 table, one write and one read port, registered read.
// A read of the address being written returns the new data.
module rc4_perm_ram (
   input  logic       clock,
   input  logic       wr_en,
   input  logic [7:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic       rd_en,
   input  logic [7:0] rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0] perm_mem [256];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= perm_mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/rc4_stream_cipher.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Word
// req       in         req_valid/req_stall  rc4_pkg::req_type (data_byte, restart)
// rsp       out        rsp_valid/rsp_stall  rc4_pkg::rsp_type (out_byte, keystream_byte)
// csr       in         csr_we               csr_index, csr_wdata (64 bits)
//
// Steady state: each byte makes three dependent accesses through the single read port
// of the table RAM; the next word may be accepted in the last step of the one before.
// Restart, or the first word after reset: identity fill, then K1, K2 and K3 per entry,
// then ST_START before the word's own steps.
// Reset is synchronous; the table keeps its contents and is refilled on first use.
// A stalled result holds the block at its last step; req_stall stays high meanwhile.
module rc4_stream_cipher #(
   parameter int KEY_MAX_BYTES = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rc4_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rc4_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [rc4_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [rc4_pkg::KEY_WORD_W-1:0]     csr_wdata
);

   localparam int KIDX_W = (KEY_MAX_BYTES > 1) ? $clog2(KEY_MAX_BYTES) : 1;
   localparam logic [rc4_pkg::KEY_LENGTH_W-1:0] KEY_MAX_LEN =
      rc4_pkg::KEY_LENGTH_W'(KEY_MAX_BYTES);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_INIT  = 4'd1;
   localparam logic [3:0] ST_K1    = 4'd2;
   localparam logic [3:0] ST_K2    = 4'd3;
   localparam logic [3:0] ST_K3    = 4'd4;
   localparam logic [3:0] ST_START = 4'd5;
   localparam logic [3:0] ST_P1    = 4'd6;
   localparam logic [3:0] ST_P2    = 4'd7;
   localparam logic [3:0] ST_P3    = 4'd8;

   logic [3:0]                          state_ff, state_in;
   logic [7:0]                          n_ff, n_in;
   logic [KIDX_W-1:0]                   kidx_ff, kidx_in;
   logic [7:0]                          i_ff, i_in;
   logic [7:0]                          j_ff, j_in;
   logic                                sched_ff, sched_in;
   logic [7:0]                          sv_ff, sv_in;
   logic                                fwd_ff, fwd_in;
   logic [7:0]                          byte_ff, byte_in;
   logic [rc4_pkg::KEY_BITS-1:0]        key_ff;
   logic [rc4_pkg::KEY_LENGTH_W-1:0]    keylen_ff;
   logic                                rsp_valid_ff;
   rc4_pkg::rsp_type                    rsp_data_ff;

   logic                                ram_we, ram_re;
   logic [7:0]                          ram_waddr, ram_wdata, ram_raddr, ram_rdata;

   logic                                req_accept, out_free, need_ks, rsp_load;
   logic [rc4_pkg::KEY_LENGTH_W-1:0]    len_eff;
   logic [4:0]                          kbyte_idx;
   logic [7:0]                          key_byte;
   logic [7:0]                          jn, t_addr, ks;

   rc4_perm_ram u_perm_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = !((state_ff == ST_IDLE) || ((state_ff == ST_P3) && out_free));
   assign req_accept = req_valid && !req_stall;
   assign need_ks    = req_data.restart || !sched_ff;
   assign rsp_load   = (state_ff == ST_P3) && out_free;

   always_comb begin
      if (keylen_ff == '0) begin
         len_eff = rc4_pkg::KEY_LENGTH_W'(1);
      end else if (keylen_ff > KEY_MAX_LEN) begin
         len_eff = KEY_MAX_LEN;
      end else begin
         len_eff = keylen_ff;
      end
   end

   assign kbyte_idx = 5'(kidx_ff);
   assign key_byte  = key_ff[{kbyte_idx, 3'b000} +: 8];
   assign jn        = j_ff + ram_rdata + key_byte;
   assign t_addr    = sv_ff + ram_rdata;
   // S[j] is written in ST_P3, after the keystream read is issued in ST_P2
   assign ks        = fwd_ff ? sv_ff : ram_rdata;

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      kidx_in   = kidx_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      sched_in  = sched_ff;
      sv_in     = sv_ff;
      fwd_in    = fwd_ff;
      byte_in   = byte_ff;
      ram_we    = 1'b0;
      ram_waddr = n_ff;
      ram_wdata = n_ff;
      ram_re    = 1'b0;
      ram_raddr = i_ff + 8'd1;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               byte_in = req_data.data_byte;
               if (need_ks) begin
                  state_in = ST_INIT;
                  n_in     = '0;
               end else begin
                  i_in     = i_ff + 8'd1;
                  ram_re   = 1'b1;
                  state_in = ST_P1;
               end
            end
         end
         ST_INIT: begin
            ram_we = 1'b1;
            n_in   = n_ff + 8'd1;
            if (n_ff == 8'hFF) begin
               ram_re    = 1'b1;
               ram_raddr = '0;
               kidx_in   = '0;
               j_in      = '0;
               state_in  = ST_K1;
            end
         end
         ST_K1: begin
            sv_in     = ram_rdata;
            j_in      = jn;
            ram_re    = 1'b1;
            ram_raddr = jn;
            if (rc4_pkg::KEY_LENGTH_W'(kidx_ff) == len_eff - 1'b1) begin
               kidx_in = '0;
            end else begin
               kidx_in = kidx_ff + KIDX_W'(1);
            end
            state_in = ST_K2;
         end
         ST_K2: begin
            ram_we    = 1'b1;
            ram_wdata = ram_rdata;
            state_in  = ST_K3;
         end
         ST_K3: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff;
            ram_wdata = sv_ff;
            n_in      = n_ff + 8'd1;
            if (n_ff == 8'hFF) begin
               i_in     = '0;
               j_in     = '0;
               sched_in = 1'b1;
               state_in = ST_START;
            end else begin
               // next entry read overlaps the S[j] write; the RAM bypass covers j == n+1
               ram_re    = 1'b1;
               ram_raddr = n_ff + 8'd1;
               state_in  = ST_K1;
            end
         end
         ST_START: begin
            i_in     = i_ff + 8'd1;
            ram_re   = 1'b1;
            state_in = ST_P1;
         end
         ST_P1: begin
            sv_in     = ram_rdata;
            j_in      = j_ff + ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = j_ff + ram_rdata;
            state_in  = ST_P2;
         end
         ST_P2: begin
            ram_we    = 1'b1;
            ram_waddr = i_ff;
            ram_wdata = ram_rdata;
            ram_re    = 1'b1;
            ram_raddr = t_addr;
            fwd_in    = (t_addr == j_ff);
            state_in  = ST_P3;
         end
         ST_P3: begin
            if (out_free) begin
               ram_we    = 1'b1;
               ram_waddr = j_ff;
               ram_wdata = sv_ff;
               state_in  = ST_IDLE;
               if (req_accept) begin
                  byte_in = req_data.data_byte;
                  if (need_ks) begin
                     state_in = ST_INIT;
                     n_in     = '0;
                  end else begin
                     i_in     = i_ff + 8'd1;
                     ram_re   = 1'b1;
                     state_in = ST_P1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         n_ff     <= '0;
         kidx_ff  <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         sched_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         kidx_ff  <= kidx_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         sched_ff <= sched_in;
      end
   end

   always_ff @(posedge clock) begin
      sv_ff   <= sv_in;
      fwd_ff  <= fwd_in;
      byte_ff <= byte_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff    <= '0;
         keylen_ff <= rc4_pkg::KEY_LENGTH_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            rc4_pkg::CSR_KEY_WORD_0: key_ff[63:0]    <= csr_wdata;
            rc4_pkg::CSR_KEY_WORD_1: key_ff[127:64]  <= csr_wdata;
            rc4_pkg::CSR_KEY_WORD_2: key_ff[191:128] <= csr_wdata;
            rc4_pkg::CSR_KEY_WORD_3: key_ff[255:192] <= csr_wdata;
            rc4_pkg::CSR_KEY_LENGTH: keylen_ff <= csr_wdata[rc4_pkg::KEY_LENGTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.out_byte       <= byte_ff ^ ks;
         rsp_data_ff.keystream_byte <= ks;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a restart word, or any word before the schedule has run, must begin the fill pass at entry zero
   a_restart_fill: assert property (@(posedge clock) disable iff (reset)
      req_accept && need_ks |=> (state_ff == ST_INIT) && (n_ff == 8'd0))
      else $error("restart did not start the table fill");

   // the schedule must leave both indices cleared and the flag set
   a_start_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_START) |-> (i_ff == 8'd0) && (j_ff == 8'd0) && sched_ff)
      else $error("indices not cleared after key schedule");

   // the j read steps rely on no write landing in the same cycle
   a_no_write_on_jread: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_K1 || state_ff == ST_P1) |-> !ram_we)
      else $error("table write during j read");

   // a finished step must present its keystream byte
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_valid_ff && (rsp_data_ff.keystream_byte == $past(ks)))
      else $error("result not loaded after last step");

endmodule
